/* rtl/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg: shared definitions for the stippled line stepper
// Widths, beat layouts and the item mode codes used by every module.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  // Coordinate width, and the widths of the walk arithmetic that follow from it.
  localparam int CoordW  = 16;
  localparam int DeltaW  = CoordW + 1;   // signed difference of two coordinates
  localparam int TwiceW  = CoordW + 2;   // twice a delta magnitude
  localparam int ErrW    = CoordW + 3;   // signed Bresenham error term
  localparam int StepW   = CoordW + 1;   // points still to emit
  localparam int DataW   = 32;
  localparam int StipW   = 16;

  localparam int InTdataW  = 112;
  localparam int OutTdataW = 80;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  // Packed so that the last field declared lands in the lowest bits.
  typedef struct packed {
    logic [StipW-1:0]         stipple_in;
    logic [DataW-1:0]         data_word;
    logic signed [CoordW-1:0] y_end;
    logic signed [CoordW-1:0] x_end;
    logic signed [CoordW-1:0] y_start;
    logic signed [CoordW-1:0] x_start;
  } in_fields_t;

  typedef struct packed {
    mode_e      mode;
    in_fields_t fields;
  } in_item_t;

  typedef struct packed {
    logic [StipW-1:0]         stipple_out;
    logic [DataW-1:0]         point_data;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_x;
  } out_fields_t;

  typedef struct packed {
    logic        write_enable;
    logic        last;
    out_fields_t fields;
  } out_item_t;

endpackage : lss_pkg

`default_nettype wire

/* rtl/stippled_line_stepper_top.sv */
// ----------------------------------------------------------------------------
// stippled_line_stepper_top: Bresenham line walker with a 16-bit stipple
// Streams one result beat for every input beat, start or step.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless the output side stalls and
// returns one result beat for each, via the input and result registers. A
// start beat (tuser 0) loads both endpoints, the payload and the pattern and
// answers with the start point, write enable low and the loaded pattern; its
// tlast is high when the line has zero length. Each step beat (tuser 1)
// returns the current point with write enable equal to pattern bit 0, then
// advances the Bresenham error term, moves one unit along the major axis
// (and the minor axis when the error turns non-negative) and rotates the
// pattern right by one. Equal x and y magnitudes walk y-major, and the end
// point itself is never emitted. tlast marks the final point of a line; step
// beats given with no active line return the held point, write enable low,
// tlast high and the unrotated pattern. The rate of one beat per cycle, unless
// the output side stalls, is set by the walk state loop, an error add and sign
// test that closes in the same cycle as the result register load. An input
// register and a result register part the two sides, so a new beat is
// accepted while a finished result still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stippled_line_stepper_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: x_start, y_start, x_end, y_end, data_word, stipple_in.
  input  wire logic [lss_pkg::InTdataW-1:0]   s_axis_tdata,
  // Fields from bit 0 up: mode.
  input  wire logic [0:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // Fields from bit 0 up: point_x, point_y, point_data, stipple_out.
  output logic [lss_pkg::OutTdataW-1:0]       m_axis_tdata,
  // Fields from bit 0 up: write_enable.
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  lss_pkg::in_item_t  in_beat, held_beat;
  lss_pkg::out_item_t result, out_beat;
  logic               held_valid;
  logic               out_ready;
  logic               advance;

  // The 112 tdata bits are exactly the six input fields, no padding.
  assign in_beat.mode   = lss_pkg::mode_e'(s_axis_tuser[0]);
  assign in_beat.fields = s_axis_tdata;

  // An item moves into the walker whenever the result register can take it.
  assign advance = held_valid && out_ready;

  lss_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_beat),
    .valid_o (held_valid),
    .take_i  (advance),
    .item_o  (held_beat)
  );

  lss_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_beat),
    .result_o  (result)
  );

  lss_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .ready_o (out_ready),
    .item_i  (result),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (out_beat)
  );

  // The 80 tdata bits are exactly the four output fields, no padding.
  assign m_axis_tdata    = out_beat.fields;
  assign m_axis_tuser[0] = out_beat.write_enable;
  assign m_axis_tlast    = out_beat.last;

endmodule : stippled_line_stepper_top

`default_nettype wire

/* rtl/lss_in_reg.sv */
// ----------------------------------------------------------------------------
// lss_in_reg: input register
// Holds one accepted beat until the walker consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire lss_pkg::in_item_t item_i,
  output logic                   valid_o,
  input  wire logic              take_i,
  output lss_pkg::in_item_t      item_o
);

  logic              valid_q, valid_d;
  lss_pkg::in_item_t item_q;
  logic              load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : lss_in_reg

`default_nettype wire

/* rtl/lss_walker.sv */
// ----------------------------------------------------------------------------
// lss_walker: Bresenham walk state and per-item result logic
// Loads a line on a start item; steps advance an active line by one point.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_walker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire lss_pkg::in_item_t item_i,
  output lss_pkg::out_item_t     result_o
);

  localparam int CoordW = lss_pkg::CoordW;
  localparam int DeltaW = lss_pkg::DeltaW;
  localparam int TwiceW = lss_pkg::TwiceW;
  localparam int ErrW   = lss_pkg::ErrW;
  localparam int StepW  = lss_pkg::StepW;

  logic signed [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [ErrW-1:0]   error_term_q, error_term_d;
  logic [TwiceW-1:0]        twice_major_q, twice_major_d;
  logic [TwiceW-1:0]        twice_minor_q, twice_minor_d;
  logic                     x_negative_q, x_negative_d;
  logic                     y_negative_q, y_negative_d;
  logic                     x_is_major_q, x_is_major_d;
  logic [StepW-1:0]         steps_left_q, steps_left_d;
  logic [lss_pkg::StipW-1:0] pattern_q, pattern_d;
  logic [lss_pkg::DataW-1:0] held_data_q, held_data_d;

  // Start-item arithmetic.
  logic signed [DeltaW-1:0] dx, dy;
  logic [DeltaW-1:0]        adx, ady, major, minor;
  logic                     start_x_major;

  // Step arithmetic.
  logic signed [ErrW-1:0]   err_sum;
  logic                     minor_move;
  logic signed [CoordW-1:0] x_inc, y_inc;
  logic [lss_pkg::StipW-1:0] pattern_rot;

  always_comb begin
    dx = {item_i.fields.x_end[CoordW-1], item_i.fields.x_end}
       - {item_i.fields.x_start[CoordW-1], item_i.fields.x_start};
    dy = {item_i.fields.y_end[CoordW-1], item_i.fields.y_end}
       - {item_i.fields.y_start[CoordW-1], item_i.fields.y_start};
    adx = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
    ady = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);
    start_x_major = adx > ady;
    major = start_x_major ? adx : ady;
    minor = start_x_major ? ady : adx;

    err_sum    = error_term_q + $signed({1'b0, twice_minor_q});
    minor_move = !err_sum[ErrW-1];
    x_inc = x_negative_q ? CoordW'(-1) : CoordW'(1);
    y_inc = y_negative_q ? CoordW'(-1) : CoordW'(1);
    pattern_rot = {pattern_q[0], pattern_q[lss_pkg::StipW-1:1]};
  end

  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    error_term_d  = error_term_q;
    twice_major_d = twice_major_q;
    twice_minor_d = twice_minor_q;
    x_negative_d  = x_negative_q;
    y_negative_d  = y_negative_q;
    x_is_major_d  = x_is_major_q;
    steps_left_d  = steps_left_q;
    pattern_d     = pattern_q;
    held_data_d   = held_data_q;

    result_o.fields.point_x     = cur_x_q;
    result_o.fields.point_y     = cur_y_q;
    result_o.fields.point_data  = held_data_q;
    result_o.fields.stipple_out = pattern_q;
    result_o.write_enable       = 1'b0;
    result_o.last               = 1'b1;

    unique case (item_i.mode)
      lss_pkg::MODE_START: begin
        cur_x_d       = item_i.fields.x_start;
        cur_y_d       = item_i.fields.y_start;
        x_negative_d  = dx[DeltaW-1];
        y_negative_d  = dy[DeltaW-1];
        x_is_major_d  = start_x_major;
        error_term_d  = -$signed(ErrW'(major));
        twice_major_d = {major, 1'b0};
        twice_minor_d = {minor, 1'b0};
        steps_left_d  = StepW'(major);
        pattern_d     = item_i.fields.stipple_in;
        held_data_d   = item_i.fields.data_word;

        result_o.fields.point_x     = item_i.fields.x_start;
        result_o.fields.point_y     = item_i.fields.y_start;
        result_o.fields.point_data  = item_i.fields.data_word;
        result_o.fields.stipple_out = item_i.fields.stipple_in;
        result_o.last               = (major == '0);
      end
      lss_pkg::MODE_STEP: begin
        if (steps_left_q != '0) begin
          if (x_is_major_q) begin
            cur_x_d = cur_x_q + x_inc;
            if (minor_move) begin
              cur_y_d = cur_y_q + y_inc;
            end
          end else begin
            cur_y_d = cur_y_q + y_inc;
            if (minor_move) begin
              cur_x_d = cur_x_q + x_inc;
            end
          end
          error_term_d = minor_move ? err_sum - $signed({1'b0, twice_major_q}) : err_sum;
          pattern_d    = pattern_rot;
          steps_left_d = steps_left_q - StepW'(1);

          result_o.write_enable       = pattern_q[0];
          result_o.last               = (steps_left_q == StepW'(1));
          result_o.fields.stipple_out = pattern_rot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      error_term_q  <= '0;
      twice_major_q <= '0;
      twice_minor_q <= '0;
      x_negative_q  <= 1'b0;
      y_negative_q  <= 1'b0;
      x_is_major_q  <= 1'b0;
      steps_left_q  <= '0;
      pattern_q     <= '0;
      held_data_q   <= '0;
    end else if (advance_i) begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      error_term_q  <= error_term_d;
      twice_major_q <= twice_major_d;
      twice_minor_q <= twice_minor_d;
      x_negative_q  <= x_negative_d;
      y_negative_q  <= y_negative_d;
      x_is_major_q  <= x_is_major_d;
      steps_left_q  <= steps_left_d;
      pattern_q     <= pattern_d;
      held_data_q   <= held_data_d;
    end
  end

  // While a line is active the error term stays below zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (steps_left_q != '0) |-> error_term_q[ErrW-1])
    else $error("error term not negative on an active line");

  // A step with no active line leaves the walk untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && item_i.mode == lss_pkg::MODE_STEP && steps_left_q == '0)
    |=> ($stable(cur_x_q) && $stable(cur_y_q) && $stable(pattern_q)
         && steps_left_q == '0))
    else $error("idle step changed the walk state");

  // The last flag of a consumed item matches an exhausted walk afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && result_o.last) |=> (steps_left_q == '0))
    else $error("last flagged while points remain");

  // An active step counts down by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && item_i.mode == lss_pkg::MODE_STEP && steps_left_q != '0)
    |=> (steps_left_q == $past(steps_left_q) - StepW'(1)))
    else $error("step count did not decrement");

endmodule : lss_walker

`default_nettype wire

/* rtl/lss_out_reg.sv */
// ----------------------------------------------------------------------------
// lss_out_reg: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  output logic                    ready_o,
  input  wire lss_pkg::out_item_t item_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output lss_pkg::out_item_t      item_o
);

  logic               valid_q, valid_d;
  lss_pkg::out_item_t item_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : lss_out_reg

`default_nettype wire

/* tb/tb_stippled_line_stepper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stippled_line_stepper_top: self-checking bench for the line stepper
// Walks short directed lines, then random lines, and checks every result beat
// against a cycle-free Bresenham walker kept inside the bench.
// ----------------------------------------------------------------------------
// A table of directed beats comes first. It covers the state right after
// reset, start beats at the coordinate extremes, zero-length lines, steps past
// the end of a line, x-major, y-major and equal-magnitude walks. Where a result
// is plain from the stimulus, the table carries it. Every other result is
// worked out by the bench's own walker. The random part that follows is made
// mostly of whole lines with small deltas and random payloads and patterns.
// The rest is noise: lone steps, lines cut short, extra steps past the end,
// and fully random endpoints. Both sides of the block insert random idle
// cycles, with quiet stretches where they never idle.
// ----------------------------------------------------------------------------

module tb_stippled_line_stepper_top;

  localparam int RandomBeats = 1500;
  localparam int CycleLimit  = 200000;
  localparam int TailCycles  = 10;

  // One expected result beat, in the block's own field widths.
  typedef struct packed {
    logic signed [lss_pkg::CoordW-1:0] x;
    logic signed [lss_pkg::CoordW-1:0] y;
    logic [lss_pkg::DataW-1:0]         data;
    logic                              wr;
    logic                              lst;
    logic [lss_pkg::StipW-1:0]         stip;
  } point_t;

  // One row of the directed table.
  typedef struct {
    lss_pkg::mode_e      m;
    lss_pkg::in_fields_t f;
    bit                  typed;
    point_t              want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [lss_pkg::InTdataW-1:0]  s_axis_tdata;
  logic [0:0]                    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lss_pkg::OutTdataW-1:0] m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  stippled_line_stepper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walker state, mirroring what the block holds between beats.
  logic signed [lss_pkg::CoordW-1:0] cur_x, cur_y;
  int                                err_term, twice_maj, twice_min, steps_left;
  bit                                x_neg, y_neg, x_major;
  logic [lss_pkg::StipW-1:0]         pattern;
  logic [lss_pkg::DataW-1:0]         held_data;

  point_t    pending_points[$];
  plan_row_t plan_q[$];

  int  errors = 0;
  int  beats_sent = 0;
  int  points_checked = 0;
  int  lines_started = 0;
  int  cycle_cnt = 0;
  // While set, neither side inserts idle cycles.
  bit  quiet = 1'b0;

  // Applies one accepted input beat to the walker and returns its result.
  task automatic advance_walker(input lss_pkg::mode_e m, input lss_pkg::in_fields_t f,
                                output point_t p);
    int x0, y0, x1, y1, dx, dy, adx, ady;
    x0 = $signed(f.x_start);
    y0 = $signed(f.y_start);
    x1 = $signed(f.x_end);
    y1 = $signed(f.y_end);
    if (m == lss_pkg::MODE_START) begin
      dx        = x1 - x0;
      dy        = y1 - y0;
      adx       = dx < 0 ? -dx : dx;
      ady       = dy < 0 ? -dy : dy;
      cur_x     = f.x_start;
      cur_y     = f.y_start;
      x_neg     = dx < 0;
      y_neg     = dy < 0;
      held_data = f.data_word;
      pattern   = f.stipple_in;
      // Equal magnitudes fall to the y-major walk.
      x_major   = adx > ady;
      if (x_major) begin
        err_term   = -adx;
        twice_maj  = 2 * adx;
        twice_min  = 2 * ady;
        steps_left = adx;
      end else begin
        err_term   = -ady;
        twice_maj  = 2 * ady;
        twice_min  = 2 * adx;
        steps_left = ady;
      end
      p = '{cur_x, cur_y, held_data, 1'b0, steps_left == 0, pattern};
    end else if (steps_left == 0) begin
      // No active line: report the held point and leave everything alone.
      p = '{cur_x, cur_y, held_data, 1'b0, 1'b1, pattern};
    end else begin
      p.x    = cur_x;
      p.y    = cur_y;
      p.data = held_data;
      p.wr   = pattern[0];
      err_term = err_term + twice_min;
      if (x_major) cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      else         cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      if (err_term >= 0) begin
        err_term = err_term - twice_maj;
        if (x_major) cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        else         cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      pattern    = {pattern[0], pattern[lss_pkg::StipW-1:1]};
      steps_left = steps_left - 1;
      p.lst      = steps_left == 0;
      p.stip     = pattern;
    end
  endtask

  // Drives one beat, waits for it to be taken, and files its expected result.
  // A table row may carry its own expectation; the walker still advances.
  task automatic send_beat(input lss_pkg::mode_e m, input lss_pkg::in_fields_t f,
                           input bit typed, input point_t want);
    int     gap;
    point_t p;
    if ($urandom_range(0, 79) == 0) quiet = ~quiet;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    s_axis_tuser  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_walker(m, f, p);
    pending_points.push_back(typed ? want : p);
    beats_sent++;
    if (m == lss_pkg::MODE_START) lines_started++;
  endtask

  function automatic lss_pkg::in_fields_t junk_fields();
    junk_fields = {$urandom(), $urandom(), $urandom(), 16'($urandom())};
  endfunction

  task automatic add_row(input lss_pkg::mode_e m, input int x0, y0, x1, y1,
                         input logic [lss_pkg::DataW-1:0] d,
                         input logic [lss_pkg::StipW-1:0] s,
                         input bit typed, input point_t want);
    plan_row_t r;
    r.m                = m;
    r.f.x_start        = 16'(x0);
    r.f.y_start        = 16'(y0);
    r.f.x_end          = 16'(x1);
    r.f.y_end          = 16'(y1);
    r.f.data_word      = d;
    r.f.stipple_in     = s;
    r.typed            = typed;
    r.want             = want;
    plan_q.push_back(r);
  endtask

  // A random line. Most have small deltas and start far enough from the
  // coordinate edges that the end point does not wrap.
  task automatic random_line();
    int                  span, dx, dy, x0, y0, len, n, pick;
    lss_pkg::in_fields_t f;
    span = ($urandom_range(0, 29) == 0) ? 200 : 24;
    dx   = int'($urandom_range(0, 2 * span)) - span;
    dy   = int'($urandom_range(0, 2 * span)) - span;
    if ($urandom_range(0, 7) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
    x0   = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
    y0   = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
    f.x_start    = 16'(x0);
    f.y_start    = 16'(y0);
    f.x_end      = 16'(x0 + dx);
    f.y_end      = 16'(y0 + dy);
    f.data_word  = $urandom();
    f.stipple_in = 16'($urandom());
    send_beat(lss_pkg::MODE_START, f, 1'b0, '0);
    len  = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                     : (dy < 0 ? -dy : dy);
    pick = $urandom_range(0, 9);
    if (pick == 0)      n = $urandom_range(0, len);      // abandoned early
    else if (pick == 1) n = len + $urandom_range(1, 2);  // steps past the end
    else                n = len;
    repeat (n) send_beat(lss_pkg::MODE_STEP, junk_fields(), 1'b0, '0);
  endtask

  // Result side: checks each accepted beat against the oldest expectation.
  function automatic void check_field(string name, logic [lss_pkg::DataW-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    lss_pkg::out_fields_t o;
    point_t               e;
    o = m_axis_tdata;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_points.pop_front();
        check_field("point_x", 32'(e.x), 32'(o.point_x));
        check_field("point_y", 32'(e.y), 32'(o.point_y));
        check_field("point_data", e.data, o.point_data);
        check_field("write_enable", 32'(e.wr), 32'(m_axis_tuser));
        check_field("last", 32'(e.lst), 32'(m_axis_tlast));
        check_field("stipple_out", 32'(e.stip), 32'(o.stipple_out));
        points_checked++;
      end
    end
  end

  // Result side back pressure: a random stall before each beat is taken.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog for a block that stops answering.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int first_random;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= lss_pkg::MODE_START;

    // Directed table. Typed expectations sit only on rows whose result is
    // plain from the inputs; the rest are left to the walker.
    add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b1,
            '{16'sd0, 16'sd0, 32'h0, 1'b0, 1'b1, 16'h0});
    // Full-range diagonal: equal magnitudes, so the walk is y-major.
    add_row(lss_pkg::MODE_START, -32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 16'hFFFF,
            1'b1, '{16'sh8000, 16'sh8000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'hFFFF});
    add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(lss_pkg::MODE_START, 32767, -32768, -32768, 32767, 32'h0, 16'h0, 1'b1,
            '{16'sh7FFF, 16'sh8000, 32'h0, 1'b0, 1'b0, 16'h0});
    add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    // Longest x-major walk, running toward negative x.
    add_row(lss_pkg::MODE_START, 32767, 0, -32768, 1, 32'h1234_5678, 16'h8001, 1'b1,
            '{16'sh7FFF, 16'sh0, 32'h1234_5678, 1'b0, 1'b0, 16'h8001});
    add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    // Zero-length line: finished at once, and a step after it is idle.
    add_row(lss_pkg::MODE_START, 5, 5, 5, 5, 32'h0, 16'h0, 1'b1,
            '{16'sd5, 16'sd5, 32'h0, 1'b0, 1'b1, 16'h0});
    add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b1,
            '{16'sd5, 16'sd5, 32'h0, 1'b0, 1'b1, 16'h0});
    // Short x-major line walked to its end plus one extra step.
    add_row(lss_pkg::MODE_START, 0, 0, 5, 2, 32'hA5A5_A5A5, 16'h8001, 1'b0, '0);
    repeat (6) add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    // Short y-major line in the negative direction on both axes.
    add_row(lss_pkg::MODE_START, 3, -1, 1, -5, 32'h5A5A_5A5A, 16'h5555, 1'b0, '0);
    repeat (4) add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    // Equal magnitudes on a short line.
    add_row(lss_pkg::MODE_START, 0, 0, -3, 3, 32'hC3C3_C3C3, 16'hFFFE, 1'b0, '0);
    repeat (3) add_row(lss_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) send_beat(plan_q[i].m, plan_q[i].f, plan_q[i].typed, plan_q[i].want);

    first_random = beats_sent;
    while (beats_sent - first_random < RandomBeats) begin
      case ($urandom_range(0, 19))
        0: begin
          // Fully random endpoints; usually a long line that gets dropped.
          send_beat(lss_pkg::MODE_START, junk_fields(), 1'b0, '0);
          repeat ($urandom_range(0, 5)) send_beat(lss_pkg::MODE_STEP, junk_fields(), 1'b0, '0);
        end
        1: send_beat(lss_pkg::MODE_STEP, junk_fields(), 1'b0, '0);
        default: random_line();
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_points.size() != 0) begin
      $error("%0d expected results never arrived", pending_points.size());
      errors++;
    end

    $display("Run covered %0d lines in %0d input beats; %0d result beats compared.",
             lines_started, beats_sent, points_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
